// ===== rtl/rgbhsl_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared types and widths for the RGB to HSL converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbhsl_pkg;

  localparam int unsigned COMP_W    = 8;   // one color component
  localparam int unsigned FRAC_W    = 16;  // hue, saturation, lightness
  localparam int unsigned HUE_DIV_W = 11;  // 6 * delta, up to 1530
  localparam int unsigned SAT_DIV_W = 8;   // saturation denominator, up to 255

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [FRAC_W-1:0] hue;
    logic [FRAC_W-1:0] saturation;
    logic [FRAC_W-1:0] lightness;
  } pix_out_t;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } max_sel_e;

endpackage

`default_nettype wire

// ===== rtl/rgb_to_hsl_converter_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_unit
// Converts one RGB pixel to hue, saturation and lightness fractions.
// ----------------------------------------------------------------------------
// pipeline: 2 front stages (a, b) then 16 divider stages, one quotient bit
//   per stage in each divider
// throughput: one pixel per cycle; a stall at the output freezes the pipeline
//   and a one-entry skid register absorbs the beat in flight at the input
// reset: asynchronous, clears all valid bits and the skid entry; no data state
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsl_converter_unit
  import rgbhsl_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          stall_o,
  input  wire pix_in_t  pix_i,
  output logic          valid_o,
  input  wire logic     stall_i,
  output pix_out_t      pix_o
);

  localparam int unsigned NUM_W = HUE_DIV_W + 1;  // signed hue numerator

  logic    en;
  logic    skid_vld_q;
  pix_in_t skid_q;
  pix_in_t src;
  logic    src_vld;

  // stage a
  logic                a_vld_q;
  logic [COMP_W-1:0]   a_d_q;
  logic [COMP_W:0]     a_t_q;
  max_sel_e            a_sel_q;
  logic [COMP_W:0]     a_diff_q;
  logic [COMP_W-1:0]   mx, mn;
  max_sel_e            sel;
  logic [COMP_W:0]     diff;

  // stage b
  logic                 b_vld_q;
  logic [HUE_DIV_W-1:0] b_hue_num_q, b_hue_div_q;
  logic [SAT_DIV_W-1:0] b_sat_hi_q, b_sat_div_q;
  logic [FRAC_W-1:0]    b_sat_lo_q, b_lig_q;
  logic [HUE_DIV_W-1:0] den6, base;
  logic [NUM_W-1:0]     n_raw, n_fix;
  logic [COMP_W:0]     t_far;
  logic [SAT_DIV_W-1:0] sat_den;
  logic [FRAC_W-1:0]    lig;

  logic              vld_q [FRAC_W];
  logic [FRAC_W-1:0] lig_q [FRAC_W];
  logic [FRAC_W-1:0] hue_quo, sat_quo;

  assign en      = !(valid_o && stall_i);
  assign stall_o = skid_vld_q;
  assign src     = skid_vld_q ? skid_q : pix_i;
  assign src_vld = skid_vld_q || valid_i;

  // skid entry catches a beat taken while the pipeline is frozen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (en) begin
      skid_vld_q <= 1'b0;
    end else if (valid_i && !skid_vld_q) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && valid_i && !skid_vld_q) begin
      skid_q <= pix_i;
    end
  end

  // max, min and the signed difference that feeds the hue
  always_comb begin
    mx = src.red;
    mn = src.red;
    if (src.green > mx) mx = src.green;
    if (src.green < mn) mn = src.green;
    if (src.blue > mx) mx = src.blue;
    if (src.blue < mn) mn = src.blue;
    if (src.red == mx) begin
      sel  = SEL_RED;
      diff = {1'b0, src.green} - {1'b0, src.blue};
    end else if (src.green == mx) begin
      sel  = SEL_GREEN;
      diff = {1'b0, src.blue} - {1'b0, src.red};
    end else begin
      sel  = SEL_BLUE;
      diff = {1'b0, src.red} - {1'b0, src.green};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= src_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_d_q    <= mx - mn;
      a_t_q    <= {1'b0, mx} + {1'b0, mn};
      a_sel_q  <= sel;
      a_diff_q <= diff;
    end
  end

  // numerators and denominators for both dividers
  always_comb begin
    den6 = {1'b0, a_d_q, 2'b00} + {2'b00, a_d_q, 1'b0};
    case (a_sel_q)
      SEL_GREEN: base = {2'b00, a_d_q, 1'b0};
      SEL_BLUE:  base = {1'b0, a_d_q, 2'b00};
      default:   base = '0;
    endcase
    n_raw = {1'b0, base} + {{(NUM_W-COMP_W-1){a_diff_q[COMP_W]}}, a_diff_q};
    n_fix = n_raw[NUM_W-1] ? (n_raw + {1'b0, den6}) : n_raw;
    t_far = 9'd510 - a_t_q;
    sat_den = (a_t_q < 9'd255) ? a_t_q[COMP_W-1:0] : t_far[COMP_W-1:0];
    // t * 65535 / 510 is exactly 128 t + t / 2
    lig = {a_t_q, 7'b0} + {8'b0, a_t_q[COMP_W:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_lig_q <= lig;
      if (a_d_q == '0) begin
        // gray: zero numerators over a unit divisor give zero
        b_hue_num_q <= '0;
        b_hue_div_q <= HUE_DIV_W'(1);
        b_sat_hi_q  <= '0;
        b_sat_lo_q  <= '0;
        b_sat_div_q <= SAT_DIV_W'(1);
      end else begin
        b_hue_num_q <= n_fix[HUE_DIV_W-1:0];
        b_hue_div_q <= den6;
        // d * 65535 split as (d - 1) * 65536 + (65536 - d)
        b_sat_hi_q  <= a_d_q - COMP_W'(1);
        b_sat_lo_q  <= FRAC_W'(0) - {8'b0, a_d_q};
        b_sat_div_q <= sat_den;
      end
    end
  end

  rgbhsl_divider #(
    .DIV_W (HUE_DIV_W),
    .QUO_W (FRAC_W)
  ) u_hue_div (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (b_hue_num_q),
    .low_i ('0),
    .div_i (b_hue_div_q),
    .quo_o (hue_quo)
  );

  rgbhsl_divider #(
    .DIV_W (SAT_DIV_W),
    .QUO_W (FRAC_W)
  ) u_sat_div (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (b_sat_hi_q),
    .low_i (b_sat_lo_q),
    .div_i (b_sat_div_q),
    .quo_o (sat_quo)
  );

  // valid and lightness ride alongside the divider stages
  for (genvar k = 0; k < FRAC_W; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (en) begin
          vld_q[k] <= b_vld_q;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          lig_q[k] <= b_lig_q;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (en) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          lig_q[k] <= lig_q[k-1];
        end
      end
    end
  end

  assign valid_o          = vld_q[FRAC_W-1];
  assign pix_o.hue        = hue_quo;
  assign pix_o.saturation = sat_quo;
  assign pix_o.lightness  = lig_q[FRAC_W-1];

endmodule

`default_nettype wire

// ===== rtl/rgbhsl_divider.sv =====
// ----------------------------------------------------------------------------
// rgbhsl_divider
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbhsl_divider
  import rgbhsl_pkg::*;
#(
  parameter int unsigned DIV_W = SAT_DIV_W,
  parameter int unsigned QUO_W = FRAC_W
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [DIV_W-1:0] rem_i,  // high dividend part, below the divisor
  input  wire logic [QUO_W-1:0] low_i,  // low dividend bits, shifted in msb first
  input  wire logic [DIV_W-1:0] div_i,
  output logic      [QUO_W-1:0] quo_o
);

  logic [DIV_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [DIV_W-1:0] div_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DIV_W-1:0] p_rem;
    logic [QUO_W-1:0] p_low;
    logic [DIV_W-1:0] p_div;
    logic [QUO_W-1:0] p_quo;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign p_rem = rem_i;
      assign p_low = low_i;
      assign p_div = div_i;
      assign p_quo = '0;
    end else begin : g_next
      assign p_rem = rem_q[k-1];
      assign p_low = low_q[k-1];
      assign p_div = div_q[k-1];
      assign p_quo = quo_q[k-1];
    end

    always_comb begin
      trial = {p_rem, p_low[QUO_W-1]};
      diff  = trial - {1'b0, p_div};
      ge    = (trial >= {1'b0, p_div});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        low_q[k] <= {p_low[QUO_W-2:0], 1'b0};
        div_q[k] <= p_div;
        quo_q[k] <= {p_quo[QUO_W-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

`default_nettype wire

// ===== rtl/rgbhsl_checker.sv =====
// ----------------------------------------------------------------------------
// rgbhsl_checker
// Port-level checks for the RGB to HSL converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbhsl_checker
  import rgbhsl_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     valid_i,
  input wire logic     stall_o,
  input wire pix_in_t  pix_i,
  input wire logic     valid_o,
  input wire logic     stall_i,
  input wire pix_out_t pix_o
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(pix_o))
    else $error("result beat changed while stalled");

  // the input only stalls when a result beat was held back
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && $past(valid_o && stall_i))
    else $error("input stalled without a held result");

  // zero saturation means a gray pixel, whose hue is zero
  a_gray_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (pix_o.saturation == '0) |-> (pix_o.hue == '0))
    else $error("nonzero hue on a gray pixel");

  // a beat waiting at the input stays offered with the same payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && stall_o |=> valid_i && $stable(pix_i))
    else $error("stalled input beat changed");

endmodule

bind rgb_to_hsl_converter_unit rgbhsl_checker u_rgbhsl_checker (.*);

`default_nettype wire
